// File: hw/rtl/swrm_pkg.sv
// ----------------------------------------------------------------------------
// swrm_pkg
// shared types and constants of the sliding window rate meter
// ----------------------------------------------------------------------------
package swrm_pkg;

  // ring geometry
  localparam int unsigned Slots   = 24;
  localparam int unsigned IdxW    = $clog2(Slots);
  // sum of all slots never exceeds Slots * 2^32
  localparam int unsigned SumW    = 32 + $clog2(Slots);

  // rate scaling and budget scaling
  localparam int unsigned MsPerS      = 1000;
  localparam int unsigned MsW         = 10;
  localparam int unsigned BudgetProdW = 40;
  localparam int unsigned MulW        = SumW + MsW;

  // shared divider: restoring, DivStep quotient bits per cycle
  localparam int unsigned DivStep  = 2;
  localparam int unsigned DivIters = (MulW + DivStep - 1) / DivStep;
  localparam int unsigned DivW     = DivStep * DivIters;
  localparam int unsigned DivCntW  = $clog2(DivIters + 1);

  // apb register map
  localparam int unsigned PAddrW   = 5;
  localparam int unsigned RegIdxW  = PAddrW - 2;
  localparam logic [RegIdxW-1:0] RegSlotMerge  = 3'd0;
  localparam logic [RegIdxW-1:0] RegRateWindow = 3'd1;
  localparam logic [RegIdxW-1:0] RegBudgWindow = 3'd2;
  localparam logic [RegIdxW-1:0] RegBaseLimit  = 3'd3;
  localparam logic [RegIdxW-1:0] RegScalePct   = 3'd4;

  // register reset values
  localparam logic [15:0] RstSlotMerge  = 16'd100;
  localparam logic [15:0] RstRateWindow = 16'd2000;
  localparam logic [15:0] RstBudgWindow = 16'd1000;
  localparam logic [31:0] RstBaseLimit  = 32'd0;
  localparam logic [7:0]  RstScalePct   = 8'd100;

  localparam logic [7:0]  FullPercent = 8'd100;
  localparam logic [31:0] AllOnes     = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    CmdRecord  = 2'd0,
    CmdMeasure = 2'd1,
    CmdBudget  = 2'd2
  } cmd_e;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] now_ms;
    logic [23:0] byte_count;
  } in_beat_t;

  typedef struct packed {
    logic [31:0] rate_bytes_per_s;
    logic [31:0] budget_bytes;
    logic [63:0] total_bytes;
  } out_beat_t;

  typedef struct packed {
    logic [15:0] slot_merge_ms;
    logic [15:0] rate_window_ms;
    logic [15:0] budget_window_ms;
    logic [31:0] base_limit_bytes;
    logic [7:0]  scale_percent;
  } cfg_t;

  typedef struct packed {
    logic [31:0] stamp;
    logic [31:0] bytes;
  } slot_t;

endpackage

// File: hw/rtl/swrm_regs.sv
// ----------------------------------------------------------------------------
// swrm_regs
// apb configuration registers of the rate meter
// ----------------------------------------------------------------------------
module swrm_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [swrm_pkg::PAddrW-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  output swrm_pkg::cfg_t                cfg_o
);
  import swrm_pkg::*;

  cfg_t               cfg_q;
  logic [RegIdxW-1:0] reg_idx;
  logic               wr_en;

  assign reg_idx = paddr[PAddrW-1:2];
  assign wr_en   = psel & penable & pwrite;
  assign pready  = 1'b1;
  assign cfg_o   = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.slot_merge_ms    <= RstSlotMerge;
      cfg_q.rate_window_ms   <= RstRateWindow;
      cfg_q.budget_window_ms <= RstBudgWindow;
      cfg_q.base_limit_bytes <= RstBaseLimit;
      cfg_q.scale_percent    <= RstScalePct;
    end else if (wr_en) begin
      unique case (reg_idx)
        RegSlotMerge:  cfg_q.slot_merge_ms    <= pwdata[15:0];
        RegRateWindow: cfg_q.rate_window_ms   <= pwdata[15:0];
        RegBudgWindow: cfg_q.budget_window_ms <= pwdata[15:0];
        RegBaseLimit:  cfg_q.base_limit_bytes <= pwdata;
        RegScalePct:   cfg_q.scale_percent    <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      RegSlotMerge:  prdata = {16'd0, cfg_q.slot_merge_ms};
      RegRateWindow: prdata = {16'd0, cfg_q.rate_window_ms};
      RegBudgWindow: prdata = {16'd0, cfg_q.budget_window_ms};
      RegBaseLimit:  prdata = cfg_q.base_limit_bytes;
      RegScalePct:   prdata = {24'd0, cfg_q.scale_percent};
      default:       prdata = 32'd0;
    endcase
  end

endmodule

// File: hw/rtl/swrm_slot_store.sv
// ----------------------------------------------------------------------------
// swrm_slot_store
// slot ring memory: stamp and byte count per slot, one read and one write port
// ----------------------------------------------------------------------------
module swrm_slot_store (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        rd_en_i,
  input  logic [swrm_pkg::IdxW-1:0]   rd_addr_i,
  output swrm_pkg::slot_t             rd_data_o,
  input  logic                        wr_en_i,
  input  logic [swrm_pkg::IdxW-1:0]   wr_addr_i,
  input  swrm_pkg::slot_t             wr_data_i
);
  import swrm_pkg::*;

  slot_t            mem_q [Slots];
  slot_t            rd_q;
  logic [Slots-1:0] valid_q;
  logic             rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q <= mem_q[rd_addr_i];
    end
  end

  // never written slots read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= valid_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_vld_q ? rd_q : '0;

endmodule

// File: hw/rtl/swrm_div.sv
// ----------------------------------------------------------------------------
// swrm_div
// iterative restoring divider, wide dividend by 16-bit divisor
// ----------------------------------------------------------------------------
module swrm_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [swrm_pkg::MulW-1:0]   dividend_i,
  input  logic [15:0]                 divisor_i,
  output logic                        done_o,
  output logic [swrm_pkg::DivW-1:0]   quotient_o
);
  import swrm_pkg::*;

  logic [DivW-1:0]    dq_q, dq_d;
  logic [15:0]        rem_q, rem_d;
  logic [15:0]        dvs_q;
  logic [16:0]        trial;
  logic [DivCntW-1:0] cnt_q;
  logic               busy_q;
  logic               done_q;

  // dividend bits leave at the top, quotient bits enter at the bottom
  always_comb begin
    dq_d  = dq_q;
    rem_d = rem_q;
    trial = '0;
    for (int s = 0; s < DivStep; s++) begin
      trial = {rem_d, dq_d[DivW-1]};
      if (trial >= {1'b0, dvs_q}) begin
        rem_d = 16'(trial - {1'b0, dvs_q});
        dq_d  = {dq_d[DivW-2:0], 1'b1};
      end else begin
        rem_d = trial[15:0];
        dq_d  = {dq_d[DivW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dq_q  <= DivW'(dividend_i);
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      dq_q  <= dq_d;
      rem_q <= rem_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q  <= DivCntW'(DivIters);
        busy_q <= 1'b1;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == DivCntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o     = done_q;
  assign quotient_o = dq_q;

endmodule

// File: hw/rtl/sliding_window_rate_meter.sv
// sequence: a record passes StRec and StResp from accept to output beat; a zero-byte record,
//   an unused command and an unlimited budget go straight to StResp; measure and budget
//   pass StSweep, StDrain, StLoad, StDiv and StResp, paced by the slot ring sweep (one memory
//   read per cycle) and the shared divider (two quotient bits per cycle); a stalled full
//   output register holds the sequencer in StResp
// throughput: one item in work at a time, next accept in the cycle after the beat loads
// ----------------------------------------------------------------------------
// sliding_window_rate_meter
// ring of timestamped byte slots giving traffic rate and remaining send budget
// reset: async active low; registers take their defaults, slots read as zero
// through per-slot valid bits, so no clearing pass follows reset
// ----------------------------------------------------------------------------
module sliding_window_rate_meter (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // input channel
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  swrm_pkg::in_beat_t          in_data_i,
  // output channel
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output swrm_pkg::out_beat_t         out_data_o,
  // configuration
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [swrm_pkg::PAddrW-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import swrm_pkg::*;

  // sequencer states
  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StRec   = 3'd1;
  localparam logic [2:0] StSweep = 3'd2;
  localparam logic [2:0] StDrain = 3'd3;
  localparam logic [2:0] StLoad  = 3'd4;
  localparam logic [2:0] StDiv   = 3'd5;
  localparam logic [2:0] StResp  = 3'd6;

  cfg_t cfg;

  logic [2:0] state_q, state_d;

  // latched input beat
  logic [1:0]  cmd_q, cmd_d;
  logic [31:0] now_q, now_d;
  logic [23:0] bytes_q, bytes_d;
  logic [31:0] cutoff_q, cutoff_d;

  // meter state outside the ring
  logic [IdxW-1:0] slot_idx_q, slot_idx_d;
  logic [31:0]     open_q, open_d;
  logic [63:0]     total_q, total_d;

  // sweep
  logic [IdxW-1:0] cnt_q, cnt_d;
  logic [SumW-1:0] sum_q, sum_d;
  logic            acc_q;

  // pending result
  logic [31:0] res_rate_q, res_rate_d;
  logic [31:0] res_budget_q, res_budget_d;

  // output register
  out_beat_t out_q;
  logic      out_valid_q;
  logic      out_load;

  // slot store ports
  logic            rd_en;
  logic [IdxW-1:0] rd_addr;
  slot_t           rd_data;
  logic            wr_en;
  logic [IdxW-1:0] wr_addr;
  slot_t           wr_data;

  // divider ports
  logic                   div_start;
  logic [MulW-1:0]        div_dividend;
  logic [15:0]            div_divisor;
  logic                   div_done;
  logic [DivW-1:0]        div_quo;

  logic                   in_accept;
  logic [31:0]            elapsed;
  logic [IdxW-1:0]        next_idx;
  logic [MulW-1:0]        prod_rate;
  logic [BudgetProdW-1:0] prod_budget;
  logic [31:0]            limit;

  swrm_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  swrm_slot_store u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data)
  );

  swrm_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // one item at a time; the output register decouples a stalled consumer
  assign in_stall_o = (state_q != StIdle);
  assign in_accept  = in_valid_i & ~in_stall_o;

  // output register loads in StResp when empty or being drained this cycle
  assign out_load = (state_q == StResp) & ~(out_valid_q & out_stall_i);

  // record path helpers
  assign elapsed  = now_q - open_q;
  assign next_idx = (slot_idx_q == IdxW'(Slots - 1)) ? '0 : IdxW'(slot_idx_q + 1'b1);

  // scaling products, registered inside the divider
  assign prod_rate   = MulW'(sum_q) * MulW'(MsPerS);
  assign prod_budget = BudgetProdW'(cfg.base_limit_bytes) * BudgetProdW'(cfg.scale_percent);
  assign limit       = div_quo[31:0];

  // memory read: current slot at record accept, every slot during the sweep
  assign rd_en   = (state_q == StSweep) | (in_accept & (in_data_i.cmd == CmdRecord));
  assign rd_addr = (state_q == StSweep) ? cnt_q : slot_idx_q;

  always_comb begin
    state_d      = state_q;
    cmd_d        = cmd_q;
    now_d        = now_q;
    bytes_d      = bytes_q;
    cutoff_d     = cutoff_q;
    slot_idx_d   = slot_idx_q;
    open_d       = open_q;
    total_d      = total_q;
    cnt_d        = cnt_q;
    sum_d        = sum_q;
    res_rate_d   = res_rate_q;
    res_budget_d = res_budget_q;
    wr_en        = 1'b0;
    wr_addr      = slot_idx_q;
    wr_data      = rd_data;
    div_start    = 1'b0;
    div_dividend = MulW'(prod_budget);
    div_divisor  = 16'(FullPercent);

    // sweep accumulation uses the read data in the cycle after the read
    if (acc_q && (rd_data.stamp >= cutoff_q)) begin
      sum_d = SumW'(sum_q + SumW'(rd_data.bytes));
    end

    unique case (state_q)
      StIdle: begin
        if (in_accept) begin
          cmd_d        = in_data_i.cmd;
          now_d        = in_data_i.now_ms;
          bytes_d      = in_data_i.byte_count;
          cnt_d        = '0;
          sum_d        = '0;
          res_rate_d   = '0;
          res_budget_d = '0;
          if (in_data_i.cmd == CmdMeasure) begin
            cutoff_d = in_data_i.now_ms - {16'd0, cfg.rate_window_ms};
          end else begin
            cutoff_d = in_data_i.now_ms - {16'd0, cfg.budget_window_ms};
          end
          priority if (in_data_i.cmd == CmdRecord) begin
            // zero-byte record changes nothing
            state_d = (in_data_i.byte_count == '0) ? StResp : StRec;
          end else if (in_data_i.cmd == CmdMeasure) begin
            state_d = StSweep;
          end else if (in_data_i.cmd == CmdBudget) begin
            if (cfg.scale_percent > FullPercent) begin
              res_budget_d = AllOnes;
              state_d      = StResp;
            end else begin
              state_d = StSweep;
            end
          end else begin
            state_d = StResp;
          end
        end
      end

      StRec: begin
        // current slot is on the read port now
        wr_en = 1'b1;
        if (elapsed < {16'd0, cfg.slot_merge_ms}) begin
          wr_addr       = slot_idx_q;
          wr_data.stamp = rd_data.stamp;
          wr_data.bytes = rd_data.bytes + {8'd0, bytes_q};
        end else begin
          wr_addr       = next_idx;
          wr_data.stamp = now_q;
          wr_data.bytes = {8'd0, bytes_q};
          slot_idx_d    = next_idx;
          open_d        = now_q;
        end
        total_d = total_q + {40'd0, bytes_q};
        state_d = StResp;
      end

      StSweep: begin
        cnt_d = IdxW'(cnt_q + 1'b1);
        if (cnt_q == IdxW'(Slots - 1)) begin
          state_d = StDrain;
        end
      end

      StDrain: begin
        // last slot accumulates at this edge
        state_d = StLoad;
      end

      StLoad: begin
        div_start = 1'b1;
        if (cmd_q == CmdMeasure) begin
          div_dividend = prod_rate;
          // zero window divides by one
          div_divisor  = (cfg.rate_window_ms == '0) ? 16'd1 : cfg.rate_window_ms;
        end
        state_d = StDiv;
      end

      StDiv: begin
        if (div_done) begin
          if (cmd_q == CmdMeasure) begin
            res_rate_d = (|div_quo[DivW-1:32]) ? AllOnes : div_quo[31:0];
          end else if (sum_q >= SumW'(limit)) begin
            res_budget_d = '0;
          end else begin
            res_budget_d = limit - sum_q[31:0];
          end
          state_d = StResp;
        end
      end

      StResp: begin
        if (out_load) begin
          state_d = StIdle;
        end
      end

      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      slot_idx_q  <= '0;
      open_q      <= '0;
      total_q     <= '0;
      acc_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      slot_idx_q <= slot_idx_d;
      open_q     <= open_d;
      total_q    <= total_d;
      acc_q      <= (state_q == StSweep);
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q        <= cmd_d;
    now_q        <= now_d;
    bytes_q      <= bytes_d;
    cutoff_q     <= cutoff_d;
    cnt_q        <= cnt_d;
    sum_q        <= sum_d;
    res_rate_q   <= res_rate_d;
    res_budget_q <= res_budget_d;
    if (out_load) begin
      out_q.rate_bytes_per_s <= res_rate_q;
      out_q.budget_bytes     <= res_budget_q;
      out_q.total_bytes      <= total_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // an accepted beat makes the block busy in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> in_stall_o)
    else $error("input accepted while block did not go busy");

  // the divider only finishes while the sequencer waits for it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == StDiv))
    else $error("divider result arrived outside the divide wait");

  // ring writes only come from the record update
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> (state_q == StRec))
    else $error("slot written outside record update");

  // ring pointer stays inside the ring
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(slot_idx_q) < Slots)
    else $error("slot index beyond ring");

  // a result load always shows up as an output beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> out_valid_o)
    else $error("result load lost");

endmodule
